/* sv/lzss_pkg.sv */
// shared types and constants for the lzss decompressor
package lzss_pkg;

  localparam int CountWidth = 24;
  localparam int CfgWidth   = 24;
  localparam int RingAw     = 12;
  localparam int RingDepth  = 4096;
  localparam int DistW      = RingAw + 1;
  localparam int RemainW    = 5;

  localparam logic [3:0]         FlagCount = 4'd8;
  localparam logic [RemainW-1:0] LenBias   = 5'd2;

  // input word: one compressed byte
  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_start;
  } in_word_t;

  // output word: one decompressed byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;
  } out_word_t;

  // commands to the history unit
  typedef struct packed {
    logic clear;
    logic advance;
  } hist_cmd_t;

  // status from the history unit
  typedef struct packed {
    logic full;
    logic limit_zero;
    logic last_fill;
    logic beyond;
  } hist_stat_t;

endpackage

/* sv/lzss_ram.sv */
// generic single-write, single-read ram with registered read data
module lzss_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/lzss_hist_unit.sv */
// history pointer, produced count, copy address and limit compares
module lzss_hist_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lzss_pkg::CountWidth-1:0] limit,
  input  lzss_pkg::hist_cmd_t           cmd,
  input  logic [lzss_pkg::RingAw-1:0]   dist_raw,
  output logic [lzss_pkg::RingAw-1:0]   rd_addr,
  output logic [lzss_pkg::RingAw-1:0]   wr_addr,
  output lzss_pkg::hist_stat_t          status
);
  import lzss_pkg::*;

  localparam int CmpW = (CountWidth > DistW) ? CountWidth : DistW;

  logic [RingAw-1:0]     wp_r, wp_nxt;
  logic [CountWidth-1:0] produced_r, produced_nxt;
  logic [DistW-1:0]      dist_full;

  // pointer and count update
  always_comb begin
    wp_nxt       = wp_r;
    produced_nxt = produced_r;
    if (cmd.clear) begin
      wp_nxt       = '0;
      produced_nxt = '0;
    end else if (cmd.advance) begin
      wp_nxt       = wp_r + 1'b1;
      produced_nxt = produced_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      produced_r <= '0;
    end else begin
      wp_r       <= wp_nxt;
      produced_r <= produced_nxt;
    end
  end

  // distance zero stands for a full ring
  assign dist_full = (dist_raw == '0) ? DistW'(RingDepth) : DistW'(dist_raw);

  // copy source wraps around the ring
  assign rd_addr = wp_r - dist_raw;
  assign wr_addr = wp_r;

  // limit and distance compares
  assign status.full       = (produced_r >= limit);
  assign status.limit_zero = (limit == '0);
  assign status.last_fill  = ((produced_r + 1'b1) == limit);
  assign status.beyond     = (CmpW'(dist_full) > CmpW'(produced_r));

endmodule

/* sv/lzss_flag_byte_decompressor.sv */
// lzss decompressor top: token parser, copy sequencer and output register
// Takes one compressed byte per input word and returns decompressed bytes, one per output
// word. A flag byte or the first byte of a back-reference is only parsed in ST_IDLE; a
// literal goes on to ST_EMIT; a back-reference's second byte starts a copy of 2 to 17
// bytes, in which every copied byte is read from the history ram (registered read, in
// ST_READ) before it is written back in ST_EMIT, which keeps overlapping copies exact.
// Stalls on the output hold the sequencer in ST_EMIT. in_ready is high only between items.
// The 4096-byte history ram has no clearing pass after reset: a copy never uses data behind the
// start of the current stream and emits zero there instead. cfg_wr_data sets the output
// length of the stream; once that many bytes are out, further bytes are dropped until a word
// with stream_start set.
module lzss_flag_byte_decompressor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [lzss_pkg::CfgWidth-1:0] cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lzss_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lzss_pkg::out_word_t           out_data
);
  import lzss_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [CfgWidth-1:0]  len_cfg_r;
  logic [7:0]           flag_bits_r, flag_bits_nxt;
  logic [3:0]           flags_left_r, flags_left_nxt;
  logic [7:0]           token_low_r, token_low_nxt;
  logic                 expect_second_r, expect_second_nxt;
  logic [RingAw-1:0]    dist_r, dist_nxt;
  logic [RemainW-1:0]   remain_r, remain_nxt;
  logic [7:0]           lit_byte_r, lit_byte_nxt;
  logic                 lit_r, lit_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_data_r, out_data_nxt;

  logic                 in_acc;
  logic                 out_free;
  logic                 emit_go;
  logic                 drop;
  logic                 run_last;
  logic [7:0]           emit_byte;
  logic [7:0]           ram_rdata;
  logic [RingAw-1:0]    rd_addr;
  logic [RingAw-1:0]    wr_addr;
  logic [CountWidth-1:0] limit;
  hist_cmd_t            hcmd;
  hist_stat_t           hstat;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign emit_go  = (state_r == ST_EMIT) && out_free;
  assign limit    = CountWidth'(len_cfg_r);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r <= '0;
    end else if (cfg_wr_en) begin
      len_cfg_r <= cfg_wr_data;
    end
  end

  // history pointer and count unit
  lzss_hist_unit u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .limit    (limit),
    .cmd      (hcmd),
    .dist_raw (dist_r),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .status   (hstat)
  );

  // byte to emit: literal, history byte, or zero behind stream start
  assign emit_byte = lit_r ? lit_byte_r : (hstat.beyond ? 8'h00 : ram_rdata);
  assign run_last  = (remain_r == RemainW'(1)) || hstat.last_fill;

  // history ring
  lzss_ram #(
    .Width (8),
    .Depth (RingDepth)
  ) u_ring (
    .clk   (clk),
    .we    (emit_go),
    .waddr (wr_addr),
    .wdata (emit_byte),
    .re    (state_r == ST_READ),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // token parser and copy sequencer
  always_comb begin
    state_nxt         = state_r;
    flag_bits_nxt     = flag_bits_r;
    flags_left_nxt    = flags_left_r;
    token_low_nxt     = token_low_r;
    expect_second_nxt = expect_second_r;
    dist_nxt          = dist_r;
    remain_nxt        = remain_r;
    lit_byte_nxt      = lit_byte_r;
    lit_nxt           = lit_r;
    hcmd              = '0;
    drop              = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // stream start clears the parser before the byte is decoded
          if (in_data.stream_start) begin
            flag_bits_nxt     = '0;
            flags_left_nxt    = '0;
            token_low_nxt     = '0;
            expect_second_nxt = 1'b0;
            hcmd.clear        = 1'b1;
            drop              = hstat.limit_zero;
          end else begin
            drop = hstat.full;
          end
          if (!drop) begin
            if (expect_second_nxt) begin
              // second token byte: start the copy
              dist_nxt          = {in_data.in_byte, token_low_nxt[7:4]};
              remain_nxt        = RemainW'(token_low_nxt[3:0]) + LenBias;
              lit_nxt           = 1'b0;
              expect_second_nxt = 1'b0;
              flag_bits_nxt     = flag_bits_nxt >> 1;
              if (flags_left_nxt != '0) begin
                flags_left_nxt = flags_left_nxt - 1'b1;
              end
              state_nxt = ST_READ;
            end else if (flags_left_nxt == '0) begin
              flag_bits_nxt  = in_data.in_byte;
              flags_left_nxt = FlagCount;
            end else if (flag_bits_nxt[0]) begin
              // literal
              lit_byte_nxt  = in_data.in_byte;
              lit_nxt       = 1'b1;
              remain_nxt    = RemainW'(1);
              flag_bits_nxt = flag_bits_nxt >> 1;
              flags_left_nxt = flags_left_nxt - 1'b1;
              state_nxt     = ST_EMIT;
            end else begin
              token_low_nxt     = in_data.in_byte;
              expect_second_nxt = 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) begin
          hcmd.advance = 1'b1;
          remain_nxt   = remain_r - 1'b1;
          state_nxt    = run_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit_go) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.out_byte    = emit_byte;
      out_data_nxt.run_last    = run_last;
      out_data_nxt.stream_done = hstat.last_fill;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      flag_bits_r     <= '0;
      flags_left_r    <= '0;
      token_low_r     <= '0;
      expect_second_r <= 1'b0;
      remain_r        <= '0;
      lit_r           <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      flag_bits_r     <= flag_bits_nxt;
      flags_left_r    <= flags_left_nxt;
      token_low_r     <= token_low_nxt;
      expect_second_r <= expect_second_nxt;
      remain_r        <= remain_nxt;
      lit_r           <= lit_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dist_r     <= dist_nxt;
    lit_byte_r <= lit_byte_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // no byte is written once the stream has reached its length
  a_no_emit_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |-> !hstat.full)
    else $error("emit past output length");

  // a busy sequencer always has bytes left to produce
  a_remain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (remain_r != '0))
    else $error("sequencer busy with no bytes left");

  // literals never go through the history read
  a_lit_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> !lit_r)
    else $error("literal in history read state");

  // a pending token always sits under a flag byte
  a_token_has_flag: assert property (@(posedge clk) disable iff (!rst_n)
    expect_second_r |-> (flags_left_r != '0))
    else $error("token pending without flag bits");
`endif

endmodule
